>>> rtl/cmm_pkg.sv
// cmm_pkg: shared types and constants for the complex matrix multiply block.
// Request kinds, queued command layout, back-end state encoding.
// No dependencies.
package cmm_pkg;

  localparam int MAT_DIM_DEF = 16;
  localparam int IDX_W       = 6;
  localparam int ELEM_W      = 16;
  localparam int SUM_W       = 39;
  localparam int ACC_W       = 40;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_t;

  typedef struct packed {
    req_type_t                  kind;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic signed [ELEM_W-1:0]   re;
    logic signed [ELEM_W-1:0]   im;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

>>> rtl/cmm_front.sv
// cmm_front: accepts requests, drops out-of-range and unused kinds,
// forms queued commands. Depends on cmm_pkg.
module cmm_front #(
  parameter int MAT_DIM = cmm_pkg::MAT_DIM_DEF
) (
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [1:0]                        req_type,
  input  logic [cmm_pkg::IDX_W-1:0]         row_index,
  input  logic [cmm_pkg::IDX_W-1:0]         col_index,
  input  logic signed [cmm_pkg::ELEM_W-1:0] elem_re,
  input  logic signed [cmm_pkg::ELEM_W-1:0] elem_im,
  input  logic                              q_full,
  output logic                              push,
  output cmm_pkg::cmd_t                     push_cmd
);

  localparam logic [cmm_pkg::IDX_W:0] DIM_C = (cmm_pkg::IDX_W+1)'(MAT_DIM);

  logic keep;
  logic row_ok;
  logic col_ok;

  assign row_ok = {1'b0, row_index} < DIM_C;
  assign col_ok = {1'b0, col_index} < DIM_C;

  always_comb begin
    keep = 1'b0;
    unique case (req_type) inside
      cmm_pkg::REQ_LOAD_A, cmm_pkg::REQ_LOAD_B: keep = row_ok && col_ok;
      cmm_pkg::REQ_COMPUTE:                     keep = row_ok;
      default:                                  keep = 1'b0;
    endcase
  end

  assign push_cmd.kind = cmm_pkg::req_type_t'(req_type);
  assign push_cmd.row  = row_index;
  assign push_cmd.col  = col_index;
  assign push_cmd.re   = elem_re;
  assign push_cmd.im   = elem_im;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full && keep;

endmodule

>>> rtl/cmm_queue.sv
// cmm_queue: short command queue between front and back end.
// Depends on cmm_pkg.
module cmm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output cmm_pkg::cmd_t head
);

  localparam int PW = (cmm_pkg::QUEUE_DEPTH > 1) ? $clog2(cmm_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(cmm_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(cmm_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(cmm_pkg::QUEUE_DEPTH);

  cmm_pkg::cmd_t    entries [cmm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = count == CNT_FULL;
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/cmm_back.sv
// cmm_back: element stores, sequencer and pipelined complex multiply-accumulate
// with output register. Depends on cmm_pkg.
module cmm_back #(
  parameter int MAT_DIM = cmm_pkg::MAT_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  cmm_pkg::cmd_t                    q_head,
  output logic                             pop,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [cmm_pkg::IDX_W-1:0]        out_row,
  output logic [cmm_pkg::IDX_W-1:0]        out_col,
  output logic signed [cmm_pkg::SUM_W-1:0] sum_re,
  output logic signed [cmm_pkg::SUM_W-1:0] sum_im,
  output logic                             last
);

  localparam int IW    = (MAT_DIM > 1) ? $clog2(MAT_DIM) : 1;
  localparam int DEPTH = MAT_DIM * MAT_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = cmm_pkg::ELEM_W;
  localparam int PW    = 2 * EW;
  localparam int TW    = PW + 1;
  localparam int XW    = cmm_pkg::ACC_W;
  localparam logic [IW-1:0] K_LAST = IW'(MAT_DIM - 1);
  localparam logic [AW-1:0] DIM_A  = AW'(MAT_DIM);

  logic [PW-1:0] a_store [DEPTH];
  logic [PW-1:0] b_store [DEPTH];

  cmm_pkg::back_state_t state, state_next;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] row, row_next;

  logic          wr_a, wr_b, issue, adv, fire;
  logic [AW-1:0] ld_addr, ra, rb;

  logic                 s1_vld, s1_first, s1_lastk;
  logic [IW-1:0]        s1_col, s1_row;
  logic [PW-1:0]        a_q, b_q;
  logic                 s2_vld, s2_first, s2_lastk;
  logic [IW-1:0]        s2_col, s2_row;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic                 s3_vld, s3_first, s3_lastk;
  logic [IW-1:0]        s3_col, s3_row;
  logic signed [TW-1:0] t_re, t_im;
  logic signed [XW-1:0] acc_re, acc_im;
  logic signed [XW-1:0] acc_re_sum, acc_im_sum;

  assign ld_addr = AW'(q_head.row[IW-1:0]) * DIM_A + AW'(q_head.col[IW-1:0]);
  assign ra      = AW'(row) * DIM_A + AW'(k);
  assign rb      = AW'(k) * DIM_A + AW'(j);

  assign adv  = !(s3_vld && s3_lastk && res_valid && res_stall);
  assign fire = s3_vld && s3_lastk && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    k   <= k_next;
    j   <= j_next;
    row <= row_next;
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    j_next     = j;
    row_next   = row;
    pop        = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    issue      = 1'b0;
    unique case (state)
      cmm_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          unique case (q_head.kind) inside
            cmm_pkg::REQ_LOAD_A: wr_a = 1'b1;
            cmm_pkg::REQ_LOAD_B: wr_b = 1'b1;
            default: begin
              state_next = cmm_pkg::BK_RUN;
              k_next     = '0;
              j_next     = '0;
              row_next   = q_head.row[IW-1:0];
            end
          endcase
        end
      end
      cmm_pkg::BK_RUN: begin
        if (adv) begin
          issue = 1'b1;
          if (k == K_LAST) begin
            k_next = '0;
            if (j == K_LAST) begin
              state_next = cmm_pkg::BK_IDLE;
            end else begin
              j_next = j + 1'b1;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      default: state_next = cmm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_store[ld_addr] <= {q_head.re, q_head.im};
    end
    if (issue) begin
      a_q <= a_store[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_store[ld_addr] <= {q_head.re, q_head.im};
    end
    if (issue) begin
      b_q <= b_store[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= k == '0;
      s1_lastk <= k == K_LAST;
      s1_col   <= j;
      s1_row   <= row;
      s2_first <= s1_first;
      s2_lastk <= s1_lastk;
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      p_rr     <= $signed(a_q[PW-1:EW]) * $signed(b_q[PW-1:EW]);
      p_ii     <= $signed(a_q[EW-1:0])  * $signed(b_q[EW-1:0]);
      p_ri     <= $signed(a_q[PW-1:EW]) * $signed(b_q[EW-1:0]);
      p_ir     <= $signed(a_q[EW-1:0])  * $signed(b_q[PW-1:EW]);
      s3_first <= s2_first;
      s3_lastk <= s2_lastk;
      s3_col   <= s2_col;
      s3_row   <= s2_row;
      t_re     <= TW'(p_rr) - TW'(p_ii);
      t_im     <= TW'(p_ri) + TW'(p_ir);
    end
  end

  assign acc_re_sum = (s3_first ? XW'(0) : acc_re) + XW'(t_re);
  assign acc_im_sum = (s3_first ? XW'(0) : acc_im) + XW'(t_im);

  always_ff @(posedge clk) begin
    if (s3_vld && adv) begin
      acc_re <= acc_re_sum;
      acc_im <= acc_im_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_row <= cmm_pkg::IDX_W'(s3_row);
      out_col <= cmm_pkg::IDX_W'(s3_col);
      sum_re  <= acc_re_sum[cmm_pkg::SUM_W-1:0];
      sum_im  <= acc_im_sum[cmm_pkg::SUM_W-1:0];
      last    <= s3_col == K_LAST;
    end
  end

endmodule

>>> rtl/complex_matrix_multiply.sv
// complex_matrix_multiply: top level; request front end, command queue and
// multiply-accumulate back end. Depends on cmm_pkg, cmm_front, cmm_queue, cmm_back.
//
//   channel   handshake              payload
//   request   req_valid / req_stall  req_type row_index col_index elem_re elem_im
//   result    res_valid / res_stall  out_row out_col sum_re sum_im last
//
// A load writes its store from the queue head while idle (one store write port).
// A row request is dispatched, then issues MAT_DIM*MAT_DIM terms to the single
// complex MAC unit, one term per cycle unless the result side stalls;
// each result is registered through read, multiply, add and accumulate stages.
// Consecutive row requests leave an idle dispatch state between their term streams.
// Synchronous reset clears queue and sequencer; stores stay undefined until loaded.
// A stalled result freezes the MAC pipeline once the next result is ready; the
// queue keeps taking requests until full.
module complex_matrix_multiply #(
  parameter int MAT_DIM = cmm_pkg::MAT_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [1:0]                        req_type,
  input  logic [cmm_pkg::IDX_W-1:0]         row_index,
  input  logic [cmm_pkg::IDX_W-1:0]         col_index,
  input  logic signed [cmm_pkg::ELEM_W-1:0] elem_re,
  input  logic signed [cmm_pkg::ELEM_W-1:0] elem_im,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [cmm_pkg::IDX_W-1:0]         out_row,
  output logic [cmm_pkg::IDX_W-1:0]         out_col,
  output logic signed [cmm_pkg::SUM_W-1:0]  sum_re,
  output logic signed [cmm_pkg::SUM_W-1:0]  sum_im,
  output logic                              last
);

  logic          q_full;
  logic          q_not_empty;
  logic          push;
  logic          pop;
  cmm_pkg::cmd_t push_cmd;
  cmm_pkg::cmd_t q_head;

  cmm_front #(
    .MAT_DIM(MAT_DIM)
  ) u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .row_index (row_index),
    .col_index (col_index),
    .elem_re   (elem_re),
    .elem_im   (elem_im),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  cmm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  cmm_back #(
    .MAT_DIM(MAT_DIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .sum_re    (sum_re),
    .sum_im    (sum_im),
    .last      (last)
  );

endmodule

>>> rtl/cmm_checker.sv
// cmm_checker: port-level checks on the result channel of the top level,
// bound to complex_matrix_multiply. Depends on cmm_pkg.
module cmm_checker #(
  parameter int MAT_DIM = cmm_pkg::MAT_DIM_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              res_valid,
  input logic                              res_stall,
  input logic [cmm_pkg::IDX_W-1:0]         out_row,
  input logic [cmm_pkg::IDX_W-1:0]         out_col,
  input logic signed [cmm_pkg::SUM_W-1:0]  sum_re,
  input logic signed [cmm_pkg::SUM_W-1:0]  sum_im,
  input logic                              last
);

  localparam logic [cmm_pkg::IDX_W:0]   DIM_C    = (cmm_pkg::IDX_W+1)'(MAT_DIM);
  localparam logic [cmm_pkg::IDX_W-1:0] COL_LAST = cmm_pkg::IDX_W'(MAT_DIM - 1);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_row) && $stable(out_col)
      && $stable(sum_re) && $stable(sum_im) && $stable(last))
    else $error("result changed while stalled");

  a_last_col: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last == (out_col == COL_LAST)))
    else $error("last mark does not match final column");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ({1'b0, out_row} < DIM_C) && ({1'b0, out_col} < DIM_C))
    else $error("result row or column out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind complex_matrix_multiply cmm_checker #(.MAT_DIM(MAT_DIM)) u_cmm_checker (.*);

>>> tb/complex_matrix_multiply_tb.sv
// complex_matrix_multiply_tb: self-checking bench for the complex matrix multiply block.
// Shadow copies of both stores predict every product row; results are checked in order.
// Depends on cmm_pkg and complex_matrix_multiply.
`timescale 1ns / 1ps

module complex_matrix_multiply_tb;

  localparam int DIM = cmm_pkg::MAT_DIM_DEF;
  localparam int IDX_W = cmm_pkg::IDX_W;
  localparam int ELEM_W = cmm_pkg::ELEM_W;
  localparam int SUM_W = cmm_pkg::SUM_W;
  localparam int ROW_MID = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic                    last;
  } product_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [1:0]               req_type = cmm_pkg::REQ_LOAD_A;
  logic [IDX_W-1:0]         row_index = '0;
  logic [IDX_W-1:0]         col_index = '0;
  logic signed [ELEM_W-1:0] elem_re = '0;
  logic signed [ELEM_W-1:0] elem_im = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [SUM_W-1:0]  sum_re;
  logic signed [SUM_W-1:0]  sum_im;
  logic                     last;

  logic signed [ELEM_W-1:0] a_re [DIM*DIM];
  logic signed [ELEM_W-1:0] a_im [DIM*DIM];
  logic signed [ELEM_W-1:0] b_re [DIM*DIM];
  logic signed [ELEM_W-1:0] b_im [DIM*DIM];

  product_t expected_products[$];
  product_t want;
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles = 0;

  complex_matrix_multiply dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .row_index (row_index),
    .col_index (col_index),
    .elem_re   (elem_re),
    .elem_im   (elem_im),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .sum_re    (sum_re),
    .sum_im    (sum_im),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // hold off for a counted stretch, else stall at random
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void predict_product_row(input int r);
    longint   acc_re;
    longint   acc_im;
    longint   ar, ai, br, bi;
    product_t p;
    for (int j = 0; j < DIM; j++) begin
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < DIM; k++) begin
        ar = longint'(a_re[r*DIM+k]);
        ai = longint'(a_im[r*DIM+k]);
        br = longint'(b_re[k*DIM+j]);
        bi = longint'(b_im[k*DIM+j]);
        acc_re += ar * br - ai * bi;
        acc_im += ar * bi + ai * br;
      end
      p.row  = IDX_W'(r);
      p.col  = IDX_W'(j);
      p.re   = acc_re[SUM_W-1:0];
      p.im   = acc_im[SUM_W-1:0];
      p.last = (j == DIM - 1);
      expected_products.push_back(p);
    end
  endfunction

  function automatic void track_request(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                                        input logic [IDX_W-1:0] col,
                                        input logic signed [ELEM_W-1:0] re,
                                        input logic signed [ELEM_W-1:0] im);
    int idx;
    idx = int'(row) * DIM + int'(col);
    if (kind == cmm_pkg::REQ_LOAD_A && row < DIM && col < DIM) begin
      a_re[idx] = re;
      a_im[idx] = im;
    end else if (kind == cmm_pkg::REQ_LOAD_B && row < DIM && col < DIM) begin
      b_re[idx] = re;
      b_im[idx] = im;
    end else if (kind == cmm_pkg::REQ_COMPUTE && row < DIM) begin
      predict_product_row(int'(row));
    end
  endfunction

  function automatic logic signed [ELEM_W-1:0] random_component();
    case ($urandom_range(9))
      0: random_component = 16'sh8000;
      1: random_component = 16'sh7fff;
      2: random_component = 16'sh0000;
      3: random_component = 16'shffff;
      default: random_component = ELEM_W'($urandom);
    endcase
  endfunction

  // rows of A that hold a full set of loaded entries
  function automatic logic [IDX_W-1:0] filled_row();
    case ($urandom_range(2))
      0: filled_row = '0;
      1: filled_row = IDX_W'(ROW_MID);
      default: filled_row = IDX_W'(DIM - 1);
    endcase
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col,
                              input logic signed [ELEM_W-1:0] re,
                              input logic signed [ELEM_W-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    row_index <= row;
    col_index <= col;
    elem_re   <= re;
    elem_im   <= im;
    do @(posedge clk); while (req_stall);
    track_request(kind, row, col, re, im);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (expected_products.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: row %0d col %0d re %0d im %0d last %0b",
                   out_row, out_col, sum_re, sum_im, last);
      end else begin
        want = expected_products.pop_front();
        if (out_row !== want.row || out_col !== want.col || sum_re !== want.re ||
            sum_im !== want.im || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: got row %0d col %0d re %0d im %0d last %0b, %s %0d %0d %0d %0d %0b",
                     out_row, out_col, sum_re, sum_im, last, "expected",
                     want.row, want.col, want.re, want.im, want.last);
        end
      end
    end
  end

  // extreme values on the rows and columns the directed computes touch
  task automatic test_fill_stores();
    logic signed [ELEM_W-1:0] re, im;
    send_idle_pct = 11;
    recv_idle_pct = 70;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        if (c == 0) begin
          re = 16'sh8000;
          im = 16'sh7fff;
        end else if (c == DIM - 1) begin
          re = 16'sh7fff;
          im = 16'sh7fff;
        end else begin
          re = random_component();
          im = random_component();
        end
        send_request(cmm_pkg::REQ_LOAD_B, IDX_W'(r), IDX_W'(c), re, im);
      end
    end
    for (int r = 0; r < DIM; r++) begin
      if (r != 0 && r != ROW_MID && r != DIM - 1) continue;
      for (int c = 0; c < DIM; c++) begin
        if (r == 0) begin
          re = 16'sh8000;
          im = 16'sh8000;
        end else if (r == DIM - 1) begin
          re = 16'sh7fff;
          im = 16'sh8000;
        end else begin
          re = random_component();
          im = random_component();
        end
        send_request(cmm_pkg::REQ_LOAD_A, IDX_W'(r), IDX_W'(c), re, im);
      end
    end
    wait_drained();
  endtask

  task automatic test_directed();
    send_request(cmm_pkg::REQ_COMPUTE, 6'd0, 6'd0, '0, '0);
    send_request(cmm_pkg::REQ_COMPUTE, IDX_W'(DIM - 1), 6'd63, 16'sh7fff, 16'sh8000);
    send_request(cmm_pkg::REQ_LOAD_A, IDX_W'(DIM), 6'd0, 16'sh1234, 16'sh4321);
    send_request(cmm_pkg::REQ_LOAD_B, 6'd0, 6'd63, 16'sh7fff, 16'sh7fff);
    send_request(cmm_pkg::REQ_LOAD_A, 6'd63, 6'd63, 16'sh8000, 16'sh8000);
    send_request(cmm_pkg::REQ_LOAD_B, 6'd63, IDX_W'(DIM), 16'sh0001, 16'shffff);
    send_request(cmm_pkg::REQ_COMPUTE, 6'd63, 6'd0, '0, '0);
    send_request(cmm_pkg::REQ_COMPUTE, IDX_W'(DIM), 6'd5, '0, '0);
    send_request(REQ_UNUSED, 6'd0, 6'd0, 16'sh7fff, 16'sh7fff);
    send_request(REQ_UNUSED, 6'd63, 6'd63, 16'shffff, 16'sh8000);
    send_request(cmm_pkg::REQ_LOAD_A, IDX_W'(DIM - 1), IDX_W'(DIM - 1), 16'sh0000, 16'sh0000);
    send_request(cmm_pkg::REQ_LOAD_B, 6'd0, 6'd0, 16'shffff, 16'sh0001);
    send_request(cmm_pkg::REQ_COMPUTE, IDX_W'(DIM - 1), 6'd0, '0, '0);
    send_request(cmm_pkg::REQ_COMPUTE, 6'd0, 6'd42, '0, '0);
    send_request(cmm_pkg::REQ_COMPUTE, IDX_W'(ROW_MID), 6'd63, '0, '0);
    send_request(cmm_pkg::REQ_LOAD_A, IDX_W'(ROW_MID), 6'd3, 16'sh8000, 16'sh7fff);
    send_request(cmm_pkg::REQ_COMPUTE, IDX_W'(ROW_MID), 6'd0, '0, '0);
    wait_drained();
  endtask

  // loads dominate; computes read only rows already filled
  task automatic test_random_phase(input int count, input int s_pct, input int r_pct);
    int sent;
    int pick;
    logic [1:0] kind;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        kind = ($urandom_range(1) == 0) ? cmm_pkg::REQ_LOAD_A : cmm_pkg::REQ_LOAD_B;
        send_request(kind, IDX_W'($urandom_range(DIM - 1)), IDX_W'($urandom_range(DIM - 1)),
                     random_component(), random_component());
        sent++;
      end else if (pick < 85) begin
        send_request(cmm_pkg::REQ_COMPUTE, filled_row(), IDX_W'($urandom),
                     ELEM_W'($urandom), ELEM_W'($urandom));
        sent++;
      end else if (pick < 90) begin
        send_request(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                     ELEM_W'($urandom), ELEM_W'($urandom));
      end else if (pick < 95) begin
        kind = ($urandom_range(1) == 0) ? cmm_pkg::REQ_LOAD_A : cmm_pkg::REQ_LOAD_B;
        if ($urandom_range(1) == 0)
          send_request(kind, IDX_W'($urandom_range(63, DIM)), IDX_W'($urandom),
                       ELEM_W'($urandom), ELEM_W'($urandom));
        else
          send_request(kind, IDX_W'($urandom_range(DIM - 1)), IDX_W'($urandom_range(63, DIM)),
                       ELEM_W'($urandom), ELEM_W'($urandom));
      end else begin
        send_request(cmm_pkg::REQ_COMPUTE, IDX_W'($urandom_range(63, DIM)), IDX_W'($urandom),
                     ELEM_W'($urandom), ELEM_W'($urandom));
      end
    end
    wait_drained();
  endtask

  // hold results back so the queue fills and the request side stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 2000;
    for (int n = 0; n < 8; n++)
      send_request(cmm_pkg::REQ_COMPUTE, filled_row(), IDX_W'($urandom), '0, '0);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_fill_stores();
    test_directed();
    test_random_phase(8, 11, 70);
    test_random_phase(8, 70, 11);
    test_random_phase(8, 0, 0);
    test_backpressure();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_products.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cmm_pkg.sv
rtl/cmm_front.sv
rtl/cmm_queue.sv
rtl/cmm_back.sv
rtl/complex_matrix_multiply.sv
rtl/cmm_checker.sv
tb/complex_matrix_multiply_tb.sv
